/* rtl/assert_macros.svh */
// assertion helpers for the rtl, included by deq_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// concurrent check on a named clock and active-low reset
`define DEQ_ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("deque assertion failed");

// same check on the standard clk_i / rst_ni pair
`define DEQ_ASSERT(lbl, prop) `DEQ_ASSERT_CLK(lbl, clk_i, rst_ni, prop)

`else

`define DEQ_ASSERT_CLK(lbl, clk, rstn, prop)
`define DEQ_ASSERT(lbl, prop)

`endif

`endif

/* rtl/deq_pkg.sv */
package deq_pkg;

  // longest list answer, in result beats
  localparam int unsigned MAX_RESULTS = 32;
  localparam int unsigned RES_CNT_W   = 6;

  // command queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = 1;
  localparam int unsigned CMDQ_CNT_W = 2;

  // result queue at the output
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned OUT_CNT_W = 3;

  // action codes on the input
  typedef enum logic [2:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_LIST       = 3'd4
  } deq_action_e;

  // decoded operations for the back end
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR,
    OP_LIST,
    OP_NOP
  } deq_op_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_ELEMENT   = 3'd3,
    ST_EMPTY     = 3'd4
  } deq_status_e;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [31:0] value;
  } deq_item_t;

  typedef struct packed {
    logic signed [31:0] element;
    deq_status_e        status;
    logic               last;
  } deq_res_t;

  typedef struct packed {
    deq_op_e            op;
    logic signed [31:0] value;
  } deq_cmd_t;

endpackage

/* rtl/deq_front.sv */
module deq_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             full_o,
  input  deq_pkg::deq_item_t item_i,
  output logic             cmd_valid_o,
  output deq_pkg::deq_cmd_t cmd_o,
  input  logic             cmd_pop_i
);

  deq_pkg::deq_cmd_t                     cmdq_q [deq_pkg::CMDQ_DEPTH];
  logic [deq_pkg::CMDQ_PTR_W-1:0]        wr_ptr_q, wr_ptr_d;
  logic [deq_pkg::CMDQ_PTR_W-1:0]        rd_ptr_q, rd_ptr_d;
  logic [deq_pkg::CMDQ_CNT_W-1:0]        cnt_q, cnt_d;
  deq_pkg::deq_cmd_t                     cmd_new;
  logic                                  wr_en;
  logic                                  rd_en;

  // classify the incoming action
  always_comb begin
    cmd_new.value = item_i.value;
    case (item_i.action)
      deq_pkg::ACT_PUSH_FRONT: cmd_new.op = deq_pkg::OP_PUSH_FRONT;
      deq_pkg::ACT_PUSH_REAR:  cmd_new.op = deq_pkg::OP_PUSH_REAR;
      deq_pkg::ACT_POP_FRONT:  cmd_new.op = deq_pkg::OP_POP_FRONT;
      deq_pkg::ACT_POP_REAR:   cmd_new.op = deq_pkg::OP_POP_REAR;
      deq_pkg::ACT_LIST:       cmd_new.op = deq_pkg::OP_LIST;
      default:                 cmd_new.op = deq_pkg::OP_NOP;
    endcase
  end

  // command queue handshake
  assign full_o      = (cnt_q == deq_pkg::CMDQ_CNT_W'(deq_pkg::CMDQ_DEPTH));
  assign cmd_valid_o = (cnt_q != '0);
  assign cmd_o       = cmdq_q[rd_ptr_q];
  assign wr_en       = push_i && !full_o;
  assign rd_en       = cmd_pop_i && cmd_valid_o;

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      cmdq_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

/* rtl/deq_res_fifo.sv */
module deq_res_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  deq_pkg::deq_res_t             res_i,
  output logic                          empty_o,
  input  logic                          pop_i,
  output deq_pkg::deq_res_t             res_o,
  output logic [deq_pkg::OUT_CNT_W-1:0] cnt_o
);

  deq_pkg::deq_res_t              buf_q [deq_pkg::OUT_DEPTH];
  logic [deq_pkg::OUT_PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [deq_pkg::OUT_PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [deq_pkg::OUT_CNT_W-1:0]  cnt_q, cnt_d;
  logic                           rd_en;

  assign empty_o = (cnt_q == '0);
  assign res_o   = buf_q[rd_ptr_q];
  assign cnt_o   = cnt_q;
  assign rd_en   = pop_i && !empty_o;

  // pointer and fill tracking, writer guarantees room
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_en ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // beat storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= res_i;
    end
  end

endmodule

/* rtl/deq_back.sv */
`include "assert_macros.svh"

module deq_back #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_valid_i,
  input  deq_pkg::deq_cmd_t             cmd_i,
  output logic                          cmd_pop_o,
  input  logic [deq_pkg::OUT_CNT_W-1:0] fifo_cnt_i,
  output logic                          res_valid_o,
  output deq_pkg::deq_res_t             res_o
);

  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (CW > deq_pkg::RES_CNT_W) ? CW : deq_pkg::RES_CNT_W;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_e;

  state_e                 state_q, state_d;
  logic [IW-1:0]          head_q, head_d;
  logic [IW-1:0]          tail_q, tail_d;
  logic [CW-1:0]          count_q, count_d;
  logic [IW-1:0]          walk_idx_q, walk_idx_d;
  logic [LW-1:0]          walk_left_q, walk_left_d;
  logic                   s2_valid_q, s2_valid_d;
  deq_pkg::deq_status_e   s2_status_q, s2_status_d;
  logic                   s2_last_q, s2_last_d;
  logic                   s2_elem_q, s2_elem_d;

  logic signed [31:0]     mem_q [CAPACITY];
  logic signed [31:0]     rd_data_q;
  logic                   mem_wr_en;
  logic [IW-1:0]          mem_waddr;
  logic                   mem_rd_en;
  logic [IW-1:0]          mem_raddr;

  logic                   room;
  logic                   store_full;
  logic [LW-1:0]          count_ext;
  logic [LW-1:0]          list_n;

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
    ring_next = (i == IW'(CAPACITY - 1)) ? '0 : i + IW'(1);
  endfunction

  function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
    ring_prev = (i == '0) ? IW'(CAPACITY - 1) : i - IW'(1);
  endfunction

  // reserve a result slot for the beat in flight plus the new one
  assign room = ((4'(fifo_cnt_i) + 4'(s2_valid_q)) < 4'(deq_pkg::OUT_DEPTH));
  assign store_full = (count_q == CW'(CAPACITY));

  // list length, capped at the result limit
  assign count_ext = LW'(count_q);
  assign list_n    = (count_ext > LW'(deq_pkg::MAX_RESULTS)) ?
                     LW'(deq_pkg::MAX_RESULTS) : count_ext;

  // execute one command, or one element of a list walk
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    count_d     = count_q;
    walk_idx_d  = walk_idx_q;
    walk_left_d = walk_left_q;
    cmd_pop_o   = 1'b0;
    mem_wr_en   = 1'b0;
    mem_waddr   = tail_q;
    mem_rd_en   = 1'b0;
    mem_raddr   = head_q;
    s2_valid_d  = 1'b0;
    s2_status_d = deq_pkg::ST_DONE;
    s2_last_d   = 1'b1;
    s2_elem_d   = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i && room) begin
          cmd_pop_o  = 1'b1;
          s2_valid_d = 1'b1;
          case (cmd_i.op)
            deq_pkg::OP_PUSH_FRONT: begin
              if (store_full) begin
                s2_status_d = deq_pkg::ST_OVERFLOW;
              end else begin
                head_d    = ring_prev(head_q);
                mem_wr_en = 1'b1;
                mem_waddr = ring_prev(head_q);
                count_d   = count_q + CW'(1);
              end
            end
            deq_pkg::OP_PUSH_REAR: begin
              if (store_full) begin
                s2_status_d = deq_pkg::ST_OVERFLOW;
              end else begin
                tail_d    = ring_next(tail_q);
                mem_wr_en = 1'b1;
                mem_waddr = tail_q;
                count_d   = count_q + CW'(1);
              end
            end
            deq_pkg::OP_POP_FRONT: begin
              if (count_q == '0) begin
                s2_status_d = deq_pkg::ST_UNDERFLOW;
              end else begin
                head_d  = ring_next(head_q);
                count_d = count_q - CW'(1);
              end
            end
            deq_pkg::OP_POP_REAR: begin
              if (count_q == '0) begin
                s2_status_d = deq_pkg::ST_UNDERFLOW;
              end else begin
                tail_d  = ring_prev(tail_q);
                count_d = count_q - CW'(1);
              end
            end
            deq_pkg::OP_LIST: begin
              if (count_q == '0) begin
                s2_status_d = deq_pkg::ST_EMPTY;
              end else begin
                mem_rd_en   = 1'b1;
                mem_raddr   = head_q;
                s2_status_d = deq_pkg::ST_ELEMENT;
                s2_elem_d   = 1'b1;
                s2_last_d   = (list_n == LW'(1));
                walk_idx_d  = ring_next(head_q);
                walk_left_d = list_n - LW'(1);
                if (list_n != LW'(1)) begin
                  state_d = S_WALK;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_WALK: begin
        if (room) begin
          mem_rd_en   = 1'b1;
          mem_raddr   = walk_idx_q;
          s2_valid_d  = 1'b1;
          s2_status_d = deq_pkg::ST_ELEMENT;
          s2_elem_d   = 1'b1;
          s2_last_d   = (walk_left_q == LW'(1));
          walk_idx_d  = ring_next(walk_idx_q);
          walk_left_d = walk_left_q - LW'(1);
          if (walk_left_q == LW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state and result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      count_q     <= '0;
      walk_idx_q  <= '0;
      walk_left_q <= '0;
      s2_valid_q  <= 1'b0;
      s2_status_q <= deq_pkg::ST_DONE;
      s2_last_q   <= 1'b0;
      s2_elem_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      count_q     <= count_d;
      walk_idx_q  <= walk_idx_d;
      walk_left_q <= walk_left_d;
      s2_valid_q  <= s2_valid_d;
      s2_status_q <= s2_status_d;
      s2_last_q   <= s2_last_d;
      s2_elem_q   <= s2_elem_d;
    end
  end

  // element store, one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      mem_q[mem_waddr] <= cmd_i.value;
    end
    if (mem_rd_en) begin
      rd_data_q <= mem_q[mem_raddr];
    end
  end

  // result beat toward the output queue
  assign res_valid_o    = s2_valid_q;
  assign res_o.element  = s2_elem_q ? rd_data_q : '0;
  assign res_o.status   = s2_status_q;
  assign res_o.last     = s2_last_q;

  `DEQ_ASSERT(count_in_range_a, count_q <= CW'(CAPACITY))
  `DEQ_ASSERT(no_res_overrun_a, s2_valid_q |-> (fifo_cnt_i < deq_pkg::OUT_CNT_W'(deq_pkg::OUT_DEPTH)))
  `DEQ_ASSERT(walk_nonzero_a, (state_q == S_WALK) |-> (walk_left_q != '0))
  `DEQ_ASSERT(single_port_a, !(mem_wr_en && mem_rd_en))
  `DEQ_ASSERT(empty_ring_a, (count_q == '0) |-> (head_q == tail_q))

endmodule

/* rtl/double_ended_queue.sv */
// Double-ended queue of signed 32-bit values in a ring store of CAPACITY
// entries. Each input beat is one action (push front, push rear, pop front,
// pop rear, list); pushes and pops give one result beat each, a list gives
// one beat per stored element from front to rear (at most 32, the last one
// flagged) or a single queue-empty beat. Actions are taken into a two-entry
// command queue, so the input can accept while the back end works. Push and
// pop sustain one action per cycle while the output queue has room; a list
// reads the single-port element store once per element, and the back end
// takes no new action until the walk ends. A result beat passes through
// the command queue, the result stage register and a four-entry output queue.
module double_ended_queue #(
  parameter int unsigned CAPACITY = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  deq_pkg::deq_item_t item_i,
  output logic               empty,
  input  logic               pop,
  output deq_pkg::deq_res_t  result_o
);

  logic                          cmd_valid;
  deq_pkg::deq_cmd_t             cmd;
  logic                          cmd_pop;
  logic [deq_pkg::OUT_CNT_W-1:0] fifo_cnt;
  logic                          res_valid;
  deq_pkg::deq_res_t             res;

  // accept and decode actions
  deq_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  // ring store and list walk
  deq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .fifo_cnt_i  (fifo_cnt),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // result queue toward the consumer
  deq_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_valid),
    .res_i   (res),
    .empty_o (empty),
    .pop_i   (pop),
    .res_o   (result_o),
    .cnt_o   (fifo_cnt)
  );

endmodule
